// File: rtl/core/hse_pkg.sv
package hse_pkg;

  // Payload widths
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CMP_W = 12;
  localparam int unsigned SWP_W = 10;

  // Saturation limits of the totals
  localparam logic [CMP_W-1:0] CMP_MAX = '1;
  localparam logic [SWP_W-1:0] SWP_MAX = '1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_BCHK,
    ST_LD,
    ST_CH,
    ST_CMP,
    ST_SW2,
    ST_NEXT,
    ST_XINIT,
    ST_XCHK,
    ST_XRD,
    ST_XW1,
    ST_ERD,
    ST_ELD,
    ST_EWAIT
  } hse_state_e;

  // Store write source
  typedef enum logic [1:0] {
    WR_NONE,
    WR_NODE,
    WR_BIG,
    WR_END
  } hse_wr_e;

  // Store read addresses
  typedef enum logic [2:0] {
    RD_NONE,
    RD_KM1,
    RD_KID_NODE,
    RD_KID_BIG,
    RD_ROOT_END,
    RD_K
  } hse_rd_e;

  typedef enum logic [2:0] {
    K_HOLD,
    K_HALF,
    K_COUNT,
    K_DEC,
    K_INC,
    K_ZERO
  } hse_kop_e;

  typedef enum logic [1:0] {
    NODE_HOLD,
    NODE_KM1,
    NODE_BIG
  } hse_node_e;

  typedef enum logic [1:0] {
    NV_HOLD,
    NV_RDA,
    NV_RDB
  } hse_nv_e;

  typedef enum logic [1:0] {
    BIG_HOLD,
    BIG_CMP,
    BIG_ROOT
  } hse_big_e;

  typedef enum logic [1:0] {
    SIZE_HOLD,
    SIZE_COUNT,
    SIZE_KM1
  } hse_size_e;

  typedef struct packed {
    logic      load_beat;
    hse_kop_e  kop;
    hse_node_e node_sel;
    hse_nv_e   nv_sel;
    hse_big_e  big_sel;
    hse_size_e size_sel;
    hse_wr_e   wr_sel;
    hse_rd_e   rd_sel;
    logic      cmp_en;
    logic      swap_en;
    logic      out_load;
    logic      clear_set;
  } hse_cmd_t;

  typedef struct packed {
    logic k_zero;
    logic k_le_one;
    logic big_is_node;
    logic leaf;
    logic out_taken;
    logic out_last;
  } hse_status_t;

endpackage

// File: rtl/core/hse_if.sv
interface hse_in_if;
  import hse_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface hse_out_if;
  import hse_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] sorted_value;
  logic             end_of_set;
  logic [CMP_W-1:0] comparisons;
  logic [SWP_W-1:0] swaps;
  logic             overflowed;

  modport source (
    output valid, output sorted_value, output end_of_set, output comparisons,
    output swaps, output overflowed, input ready
  );
  modport sink (
    input valid, input sorted_value, input end_of_set, input comparisons,
    input swaps, input overflowed, output ready
  );
endinterface

// File: rtl/core/hse_ram.sv
module hse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: rtl/core/hse_datapath.sv
module hse_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hse_pkg::hse_cmd_t           cmd_i,
  input  logic [hse_pkg::VAL_W-1:0]   in_value_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [hse_pkg::VAL_W-1:0]   out_value_o,
  output logic                        out_eos_o,
  output logic [hse_pkg::CMP_W-1:0]   out_cmp_o,
  output logic [hse_pkg::SWP_W-1:0]   out_swp_o,
  output logic                        out_ovf_o,
  output hse_pkg::hse_status_t        status_o
);
  import hse_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = CW + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    k_q, k_d;
  logic [CW-1:0]    size_q, size_d;
  logic [AW-1:0]    node_q, node_d;
  logic [AW-1:0]    big_q, big_d;
  logic [VAL_W-1:0] nodeval_q, nodeval_d;
  logic [CMP_W-1:0] cmp_q, cmp_d;
  logic [SWP_W-1:0] swp_q, swp_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_value_q;
  logic             out_eos_q;
  logic [CMP_W-1:0] out_cmp_q;
  logic [SWP_W-1:0] out_swp_q;
  logic             out_ovf_q;

  logic [CW-1:0]    km1;
  logic [KW-1:0]    lc_node, rc_node, lc_big, rc_big, size_k;
  logic             room, rc_ok, c1, c2, c3, pick_lc, pick_rc;
  logic [AW-1:0]    big_cmp;
  logic [VAL_W-1:0] bigval, rdata_a, rdata_b;
  logic [CMP_W:0]   cmp_sum;
  logic             we;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [VAL_W-1:0] wdata;

  // Heap index arithmetic
  assign km1     = k_q - CW'(1);
  assign lc_node = (KW'(node_q) << 1) + KW'(1);
  assign rc_node = lc_node + KW'(1);
  assign lc_big  = (KW'(big_q) << 1) + KW'(1);
  assign rc_big  = lc_big + KW'(1);
  assign size_k  = KW'(size_q);
  assign room    = count_q < CAP_C;

  // Pick the largest of node and its children; ties keep the earlier one
  assign rc_ok   = rc_node < size_k;
  assign c1      = $signed(rdata_a) > $signed(nodeval_q);
  assign c2      = $signed(rdata_b) > $signed(nodeval_q);
  assign c3      = $signed(rdata_b) > $signed(rdata_a);
  assign pick_rc = rc_ok && (c1 ? c3 : c2);
  assign pick_lc = c1 && !pick_rc;
  assign big_cmp = pick_rc ? rc_node[AW-1:0] : (pick_lc ? lc_node[AW-1:0] : node_q);
  assign bigval  = pick_rc ? rdata_b : rdata_a;

  // Saturating comparison total: one or two child compares per level
  assign cmp_sum = {1'b0, cmp_q} + (rc_ok ? (CMP_W + 1)'(2) : (CMP_W + 1)'(1));

  // Store port selection
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    case (cmd_i.rd_sel)
      RD_KM1: begin
        raddr_a = km1[AW-1:0];
      end
      RD_KID_NODE: begin
        raddr_a = lc_node[AW-1:0];
        raddr_b = rc_node[AW-1:0];
      end
      RD_KID_BIG: begin
        raddr_a = lc_big[AW-1:0];
        raddr_b = rc_big[AW-1:0];
      end
      RD_ROOT_END: begin
        raddr_b = km1[AW-1:0];
      end
      RD_K: begin
        raddr_a = k_q[AW-1:0];
      end
      default: begin
        raddr_a = '0;
      end
    endcase

    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = in_value_i;
    case (cmd_i.wr_sel)
      WR_NODE: begin
        we    = 1'b1;
        waddr = node_q;
        wdata = bigval;
      end
      WR_BIG: begin
        we    = 1'b1;
        waddr = big_q;
        wdata = nodeval_q;
      end
      WR_END: begin
        we    = 1'b1;
        waddr = km1[AW-1:0];
        wdata = rdata_a;
      end
      default: begin
        we = cmd_i.load_beat && room;
      end
    endcase
  end

  hse_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // Next state of the index and total registers
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    cmp_d   = cmp_q;
    swp_d   = swp_q;
    if (cmd_i.load_beat) begin
      if (room) begin
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.cmp_en) begin
      cmp_d = cmp_sum[CMP_W] ? CMP_MAX : cmp_sum[CMP_W-1:0];
    end
    if (cmd_i.swap_en && (swp_q != SWP_MAX)) begin
      swp_d = swp_q + SWP_W'(1);
    end
    if (cmd_i.clear_set) begin
      count_d = '0;
      ovf_d   = 1'b0;
      cmp_d   = '0;
      swp_d   = '0;
    end

    case (cmd_i.kop)
      K_HALF:  k_d = count_q >> 1;
      K_COUNT: k_d = count_q;
      K_DEC:   k_d = km1;
      K_INC:   k_d = k_q + CW'(1);
      K_ZERO:  k_d = '0;
      default: k_d = k_q;
    endcase

    case (cmd_i.node_sel)
      NODE_KM1: node_d = km1[AW-1:0];
      NODE_BIG: node_d = big_q;
      default:  node_d = node_q;
    endcase

    case (cmd_i.big_sel)
      BIG_CMP:  big_d = big_cmp;
      BIG_ROOT: big_d = '0;
      default:  big_d = big_q;
    endcase

    case (cmd_i.size_sel)
      SIZE_COUNT: size_d = count_q;
      SIZE_KM1:   size_d = km1;
      default:    size_d = size_q;
    endcase

    case (cmd_i.nv_sel)
      NV_RDA:  nodeval_d = rdata_a;
      NV_RDB:  nodeval_d = rdata_b;
      default: nodeval_d = nodeval_q;
    endcase

    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      k_q         <= '0;
      size_q      <= '0;
      node_q      <= '0;
      big_q       <= '0;
      cmp_q       <= '0;
      swp_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      k_q         <= k_d;
      size_q      <= size_d;
      node_q      <= node_d;
      big_q       <= big_d;
      cmp_q       <= cmp_d;
      swp_q       <= swp_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sifted value and output beat payload
  always_ff @(posedge clk_i) begin
    nodeval_q <= nodeval_d;
    if (cmd_i.out_load) begin
      out_value_q <= rdata_a;
      out_eos_q   <= (k_q + CW'(1)) == count_q;
      out_cmp_q   <= cmp_q;
      out_swp_q   <= swp_q;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_eos_o   = out_eos_q;
  assign out_cmp_o   = out_cmp_q;
  assign out_swp_o   = out_swp_q;
  assign out_ovf_o   = out_ovf_q;

  assign status_o.k_zero      = k_q == '0;
  assign status_o.k_le_one    = k_q <= CW'(1);
  assign status_o.big_is_node = !pick_lc && !pick_rc;
  assign status_o.leaf        = lc_big >= size_k;
  assign status_o.out_taken   = out_valid_q && out_ready_i;
  assign status_o.out_last    = out_eos_q;

endmodule

// File: rtl/core/hse_ctrl.sv
module hse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  input  hse_pkg::hse_status_t status_i,
  output logic                 in_ready_o,
  output hse_pkg::hse_cmd_t    cmd_o
);
  import hse_pkg::*;

  hse_state_e state_q, state_d;
  logic       build_q, build_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      build_q <= 1'b0;
    end else begin
      state_q <= state_d;
      build_q <= build_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    build_d         = build_q;
    in_ready_o      = 1'b0;
    cmd_o.load_beat = 1'b0;
    cmd_o.kop       = K_HOLD;
    cmd_o.node_sel  = NODE_HOLD;
    cmd_o.nv_sel    = NV_HOLD;
    cmd_o.big_sel   = BIG_HOLD;
    cmd_o.size_sel  = SIZE_HOLD;
    cmd_o.wr_sel    = WR_NONE;
    cmd_o.rd_sel    = RD_NONE;
    cmd_o.cmp_en    = 1'b0;
    cmd_o.swap_en   = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.clear_set = 1'b0;

    case (state_q)
      // Collect the set, one beat per cycle
      ST_LOAD: begin
        in_ready_o      = 1'b1;
        cmd_o.load_beat = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_INIT;
        end
      end
      // Start heap build from the last parent
      ST_INIT: begin
        cmd_o.kop      = K_HALF;
        cmd_o.size_sel = SIZE_COUNT;
        build_d        = 1'b1;
        state_d        = ST_BCHK;
      end
      ST_BCHK: begin
        state_d = status_i.k_zero ? ST_XINIT : ST_LD;
      end
      ST_LD: begin
        cmd_o.node_sel = NODE_KM1;
        cmd_o.rd_sel   = RD_KM1;
        state_d        = ST_CH;
      end
      ST_CH: begin
        cmd_o.nv_sel = NV_RDA;
        cmd_o.rd_sel = RD_KID_NODE;
        state_d      = ST_CMP;
      end
      // Compare children; move the larger one up
      ST_CMP: begin
        cmd_o.cmp_en = 1'b1;
        if (status_i.big_is_node) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.wr_sel  = WR_NODE;
          cmd_o.big_sel = BIG_CMP;
          state_d       = ST_SW2;
        end
      end
      // Drop the sifted value one level and fetch the next children
      ST_SW2: begin
        cmd_o.wr_sel   = WR_BIG;
        cmd_o.swap_en  = 1'b1;
        cmd_o.node_sel = NODE_BIG;
        cmd_o.rd_sel   = RD_KID_BIG;
        state_d        = status_i.leaf ? ST_NEXT : ST_CMP;
      end
      ST_NEXT: begin
        cmd_o.kop = K_DEC;
        state_d   = build_q ? ST_BCHK : ST_XCHK;
      end
      // Extraction: move root to the end of the shrinking heap
      ST_XINIT: begin
        cmd_o.kop = K_COUNT;
        build_d   = 1'b0;
        state_d   = ST_XCHK;
      end
      ST_XCHK: begin
        if (status_i.k_le_one) begin
          cmd_o.kop = K_ZERO;
          state_d   = ST_ERD;
        end else begin
          state_d = ST_XRD;
        end
      end
      ST_XRD: begin
        cmd_o.rd_sel = RD_ROOT_END;
        state_d      = ST_XW1;
      end
      ST_XW1: begin
        cmd_o.wr_sel   = WR_END;
        cmd_o.nv_sel   = NV_RDB;
        cmd_o.big_sel  = BIG_ROOT;
        cmd_o.size_sel = SIZE_KM1;
        state_d        = ST_SW2;
      end
      // Emit the sorted set
      ST_ERD: begin
        cmd_o.rd_sel = RD_K;
        state_d      = ST_ELD;
      end
      ST_ELD: begin
        cmd_o.out_load = 1'b1;
        state_d        = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (status_i.out_taken) begin
          if (status_i.out_last) begin
            cmd_o.clear_set = 1'b1;
            state_d         = ST_LOAD;
          end else begin
            cmd_o.kop = K_INC;
            state_d   = ST_ERD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// File: rtl/core/heap_sort_engine_unit.sv
// Heapsort engine: accepts one signed 32-bit value per cycle until a beat with last set,
// then sorts the stored set (up to CAPACITY values; extra beats are dropped and flagged)
// and returns it in ascending order, end_of_set on the largest value, every beat carrying
// the saturating totals of child comparisons and swaps. Input is stalled from the last
// beat until the final result is taken. The store is one RAM with a single write port and
// two registered read ports. The build sifts each parent down one level at a time, ending
// early at a leaf or when the parent already holds the largest value; each extraction step
// moves the root to the end of the shrinking heap and sifts the new root down the same way;
// each result is then read from the store and held until taken.
module heap_sort_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  hse_in_if.sink    in_i,
  hse_out_if.source out_o
);
  import hse_pkg::*;

  hse_cmd_t    cmd;
  hse_status_t status;
  logic        in_ready;

  hse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_last_i (in_i.last),
    .status_i  (status),
    .in_ready_o(in_ready),
    .cmd_o     (cmd)
  );

  hse_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_value_i (in_i.value),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .out_value_o(out_o.sorted_value),
    .out_eos_o  (out_o.end_of_set),
    .out_cmp_o  (out_o.comparisons),
    .out_swp_o  (out_o.swaps),
    .out_ovf_o  (out_o.overflowed),
    .status_o   (status)
  );

  assign in_i.ready = in_ready;

endmodule

// File: rtl/core/hse_checker.sv
module hse_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      out_eos_i,
  input logic [hse_pkg::VAL_W-1:0] out_value_i
);
  import hse_pkg::*;

  // Input is never open while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input open while result pending");

  // A closing beat stalls input for the sort
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input still open after closing beat");

  // The final result reopens input at once
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_eos_i |=> in_ready_i)
    else $error("input not reopened after final result");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("stalled result changed");

endmodule

bind heap_sort_engine_unit hse_checker u_hse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.last),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_eos_i  (out_o.end_of_set),
  .out_value_i(out_o.sorted_value)
);

// File: test/hse_sort_checker.sv
module hse_sort_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hse_in_if           in_mon,
  hse_out_if          out_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);
  import hse_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             end_of_set;
    logic [CMP_W-1:0] comparisons;
    logic [SWP_W-1:0] swaps;
    logic             overflowed;
  } sorted_beat_t;

  // Predicted copy of the element store and the per-set totals
  logic [VAL_W-1:0] heap_mem [CAPACITY];
  int unsigned      held_n;
  logic [CMP_W-1:0] cmp_total;
  logic [SWP_W-1:0] swp_total;
  logic             dropped;
  sorted_beat_t     sorted_due [$];
  int unsigned      fails;

  function automatic void count_compare();
    if (cmp_total != CMP_MAX) cmp_total = cmp_total + 1'b1;
  endfunction

  function automatic void heap_swap(int unsigned p, int unsigned q);
    logic [VAL_W-1:0] tmp;
    tmp         = heap_mem[p];
    heap_mem[p] = heap_mem[q];
    heap_mem[q] = tmp;
    if (swp_total != SWP_MAX) swp_total = swp_total + 1'b1;
  endfunction

  // Sift a node down the heap; a child wins only when strictly greater
  function automatic void sift_heap(int unsigned size, int unsigned node);
    int unsigned big;
    int unsigned lc;
    int unsigned rc;
    bit          settled;
    settled = 1'b0;
    while (!settled) begin
      big = node;
      lc  = 2 * node + 1;
      rc  = 2 * node + 2;
      if (lc < size) begin
        count_compare();
        if ($signed(heap_mem[lc]) > $signed(heap_mem[big])) big = lc;
      end
      if (rc < size) begin
        count_compare();
        if ($signed(heap_mem[rc]) > $signed(heap_mem[big])) big = rc;
      end
      if (big == node) begin
        settled = 1'b1;
      end else begin
        heap_swap(node, big);
        node = big;
      end
    end
  endfunction

  // Heapsort the held set, queue one result beat per element, then clear the set
  function automatic void sort_set();
    sorted_beat_t beat;
    for (int unsigned k = held_n / 2; k > 0; k--) sift_heap(held_n, k - 1);
    for (int unsigned k = held_n; k > 1; k--) begin
      heap_swap(0, k - 1);
      sift_heap(k - 1, 0);
    end
    for (int unsigned k = 0; k < held_n; k++) begin
      beat.value       = heap_mem[k];
      beat.end_of_set  = (k + 1 == held_n);
      beat.comparisons = cmp_total;
      beat.swaps       = swp_total;
      beat.overflowed  = dropped;
      sorted_due.push_back(beat);
    end
    held_n    = 0;
    cmp_total = '0;
    swp_total = '0;
    dropped   = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_beat_t want;
    sorted_beat_t got;
    if (!rst_ni) begin
      held_n    = 0;
      cmp_total = '0;
      swp_total = '0;
      dropped   = 1'b0;
      fails     = 0;
      sorted_due.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // store an input beat, drop it when the set is full
      if (in_mon.valid && in_mon.ready) begin
        if (held_n < CAPACITY) begin
          heap_mem[held_n] = in_mon.value;
          held_n++;
        end else begin
          dropped = 1'b1;
        end
        if (in_mon.last) sort_set();
      end

      // compare a result beat with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.value       = out_mon.sorted_value;
        got.end_of_set  = out_mon.end_of_set;
        got.comparisons = out_mon.comparisons;
        got.swaps       = out_mon.swaps;
        got.overflowed  = out_mon.overflowed;
        if (sorted_due.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("unexpected result beat: value=%0d end=%0b", $signed(got.value),
                     got.end_of_set);
        end else begin
          want = sorted_due.pop_front();
          if (got.value !== want.value || got.end_of_set !== want.end_of_set ||
              got.comparisons !== want.comparisons || got.swaps !== want.swaps ||
              got.overflowed !== want.overflowed) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("result beat expected: value=%0d end=%0b cmp=%0d swaps=%0d ovf=%0b",
                       $signed(want.value), want.end_of_set, want.comparisons, want.swaps,
                       want.overflowed);
              $display("result beat actual:   value=%0d end=%0b cmp=%0d swaps=%0d ovf=%0b",
                       $signed(got.value), got.end_of_set, got.comparisons, got.swaps,
                       got.overflowed);
            end
          end
        end
      end

      pending_o    <= sorted_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: test/tb_heap_sort_engine_unit.sv
module tb_heap_sort_engine_unit;
  import hse_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 64;

  typedef enum int unsigned {
    MIX_WIDE,
    MIX_DUPS,
    MIX_EDGES
  } value_mix_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_count;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  hse_in_if  in_if ();
  hse_out_if out_if ();

  heap_sort_engine_unit #(
    .CAPACITY (CAPACITY)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  hse_sort_checker #(
    .CAPACITY (CAPACITY)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Drive result ready: honor a long hold-off when asked, else stall at random
  initial begin
    bit hold_done;
    hold_done    = 1'b0;
    out_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // End the run when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("no beat accepted for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_value(value_mix_e mix);
    logic [VAL_W-1:0] v;
    case (mix)
      MIX_DUPS: begin
        v = 32'($urandom_range(8)) - 32'd4;
      end
      MIX_EDGES: begin
        case ($urandom_range(5))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = '0;
          3:       v = '1;
          4:       v = 32'd1;
          default: v = $urandom();
        endcase
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  // Offer one input beat after a random idle stretch, hold it until taken
  task automatic send_beat(logic [VAL_W-1:0] value, logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.last  <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_set(int unsigned size, value_mix_e mix);
    for (int unsigned i = 0; i < size; i++) send_beat(pick_value(mix), i + 1 == size);
  endtask

  // Pause the sender until every predicted result beat has arrived
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One idling profile: a large set first, then random small and mid-size sets
  task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct,
                           int unsigned big_size, int unsigned budget);
    int unsigned sent;
    int unsigned size;
    value_mix_e  mix;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    send_set(big_size, MIX_WIDE);
    sent = big_size;
    while (sent < budget) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(12, 1);
      mix  = value_mix_e'($urandom_range(2));
      send_set(size, mix);
      sent += size;
    end
    drain_results();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.last   = 1'b0;
    rst_ni       = 1'b0;
    hold_request = 1'b0;
    snd_idle_pct = 22;
    rcv_idle_pct = 45;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element sets at both extremes
    send_beat(32'h8000_0000, 1'b1);
    send_beat(32'h7fff_ffff, 1'b1);
    // extremes mixed with a duplicate maximum
    send_beat(32'h7fff_ffff, 1'b0);
    send_beat(32'h8000_0000, 1'b0);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hffff_ffff, 1'b0);
    send_beat(32'h0000_0001, 1'b0);
    send_beat(32'h7fff_ffff, 1'b1);
    // all equal, so no child ever wins
    repeat (3) send_beat(32'd5, 1'b0);
    send_beat(32'd5, 1'b1);
    // already ascending pair
    send_beat(-32'sd5, 1'b0);
    send_beat(32'd7, 1'b1);
    // descending triple
    send_beat(32'd3, 1'b0);
    send_beat(32'd2, 1'b0);
    send_beat(32'd1, 1'b1);
    drain_results();

    // hold results back so the block stalls its input behind a closed set
    hold_request = 1'b1;
    send_set(12, MIX_WIDE);
    send_set(8, MIX_DUPS);
    drain_results();

    // overflow with the closing beat dropped, then a full set, then a long overflow
    run_phase(22, 45, CAPACITY + 1, 140);
    run_phase(45, 22, CAPACITY, 140);
    run_phase(0, 0, CAPACITY + 6, 140);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
